>>> hdl/dpt_pkg.sv
`timescale 1ns / 1ps

package dpt_pkg;

	// Fixed field widths of the transaction ports
	localparam int VADDR_W     = 16;
	localparam int PADDR_W     = 16;
	localparam int BYTE_W      = 8;
	localparam int FRAME_OUT_W = 8;

	// Request function codes
	localparam logic FUNC_READ = 1'b0;
	localparam logic FUNC_FILL = 1'b1;

	// Translator sequencer states
	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_MAP   = 7'b0001000,
		ST_ADDR  = 7'b0010000,
		ST_RD    = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

endpackage

>>> hdl/demand_paging_translator_top.sv
`timescale 1ns / 1ps

// Demand-paging address translator. A read request (func 0) splits virt_addr
// into page and offset, looks the page up in the page map and, on a miss,
// gives it the next free frame and returns fault set with data_value zero;
// on a hit it returns the physical address and the signed byte stored there.
// A fill request (func 1) writes fill_data at fill_addr in a 64 KiB physical
// memory and returns nothing. A read passes from acceptance to the response
// register through two three-stage constant dividers (page/offset split, then
// page wrap), one page-map read-modify-write, the frame-times-page-size
// multiply and one physical memory read; one request is in flight at a time,
// so a new read is taken only after the last response is loaded, and a
// stalled response holds off further requests. After reset the page map is
// cleared one entry per cycle, so requests are held off until every entry is
// cleared. Bytes never filled read back as undefined.
module demand_paging_translator_top #(
	parameter int PAGE_COUNT = 256,
	parameter int PAGE_BYTES = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_ready,
	input  logic                                   func,
	input  logic [dpt_pkg::VADDR_W-1:0]            virt_addr,
	input  logic [dpt_pkg::PADDR_W-1:0]            fill_addr,
	input  logic [dpt_pkg::BYTE_W-1:0]             fill_data,
	output logic                                   rsp_valid,
	input  logic                                   rsp_ready,
	output logic                                   fault,
	output logic [dpt_pkg::FRAME_OUT_W-1:0]        frame_num,
	output logic [dpt_pkg::PADDR_W-1:0]            phys_addr,
	output logic signed [dpt_pkg::BYTE_W-1:0]      data_value
);

	import dpt_pkg::*;

	localparam int PG_W   = $clog2(PAGE_COUNT);
	localparam int OFF_W  = $clog2(PAGE_BYTES);
	localparam int PB_W   = $clog2(PAGE_BYTES + 1);
	localparam int PA_SUM = PG_W + PB_W + 1;
	localparam int PA_W   = (PA_SUM > PADDR_W) ? PA_SUM : PADDR_W;
	localparam int FN_W   = (PG_W > FRAME_OUT_W) ? PG_W : FRAME_OUT_W;
	localparam int MEM_DEPTH = 2 ** PADDR_W;

	state_t state_q;
	state_t state_d;

	logic [PG_W-1:0]    clr_cnt_q;
	logic [PG_W-1:0]    nff_q;
	logic [PG_W-1:0]    page_q;
	logic [OFF_W-1:0]   offset_q;
	logic [PG_W-1:0]    frame_q;
	logic               fault_q;
	logic [PADDR_W-1:0] paddr_q;

	logic               rsp_valid_q;
	logic               rsp_fault_q;
	logic [FRAME_OUT_W-1:0] frame_num_q;
	logic [PADDR_W-1:0] phys_addr_q;
	logic [BYTE_W-1:0]  data_value_q;

	logic               req_acc;
	logic               rd_start;
	logic               div1_vld;
	logic [VADDR_W-1:0] div1_quot;
	logic [OFF_W-1:0]   div1_rem;
	logic               div2_vld;
	logic [PG_W-1:0]    div2_rem;

	logic               map_we;
	logic [PG_W-1:0]    map_waddr;
	logic [PG_W:0]      map_wdata;
	logic [PG_W:0]      map_rdata;
	logic               map_hit;

	logic               mem_we;
	logic               mem_re;
	logic [BYTE_W-1:0]  mem_rdata;

	logic               rsp_load;
	logic [PA_W-1:0]    pa_full;
	logic [FN_W-1:0]    frame_ext;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign rd_start  = req_acc && (func == FUNC_READ);

	// Split virtual address into page and offset
	dpt_cdiv #(
		.W       (VADDR_W),
		.DIVISOR (PAGE_BYTES)
	) u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_start),
		.dividend  (virt_addr),
		.out_valid (div1_vld),
		.quot      (div1_quot),
		.rem       (div1_rem)
	);

	// Wrap page number into the table
	dpt_cdiv #(
		.W       (VADDR_W),
		.DIVISOR (PAGE_COUNT)
	) u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div1_vld),
		.dividend  (div1_quot),
		.out_valid (div2_vld),
		.quot      (),
		.rem       (div2_rem)
	);

	// Page map: valid bit over frame number
	assign map_hit   = map_rdata[PG_W];
	assign map_we    = (state_q == ST_CLEAR) || ((state_q == ST_MAP) && !map_hit);
	assign map_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : page_q;
	assign map_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, nff_q};

	dpt_ram #(
		.WIDTH (PG_W + 1),
		.DEPTH (PAGE_COUNT)
	) u_page_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    ((state_q == ST_DIV) && div2_vld),
		.raddr (div2_rem),
		.rdata (map_rdata)
	);

	// Physical memory: fills write, reads fetch the hit byte
	assign mem_we = req_acc && (func == FUNC_FILL);
	assign mem_re = (state_q == ST_RD);

	dpt_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MEM_DEPTH)
	) u_phys_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (fill_addr),
		.wdata (fill_data),
		.re    (mem_re),
		.raddr (paddr_q),
		.rdata (mem_rdata)
	);

	assign rsp_load = (state_q == ST_OUT) && (!rsp_valid_q || rsp_ready);

	// Sequence one read transaction
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == PG_W'(PAGE_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (rd_start) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div2_vld) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP:  state_d = ST_ADDR;
			ST_ADDR: state_d = ST_RD;
			ST_RD:   state_d = ST_OUT;
			ST_OUT: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			nff_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + PG_W'(1);
			end
			// Allocate the next frame on a miss, wrapping at the table size
			if ((state_q == ST_MAP) && !map_hit) begin
				if (nff_q == PG_W'(PAGE_COUNT - 1)) begin
					nff_q <= '0;
				end else begin
					nff_q <= nff_q + PG_W'(1);
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Physical address from frame and offset
	assign pa_full = PA_W'(frame_q) * PA_W'(PAGE_BYTES) + PA_W'(offset_q);
	assign frame_ext = FN_W'(frame_q);

	// Capture per-transaction payload
	always_ff @(posedge clk) begin
		if (div1_vld) begin
			offset_q <= div1_rem;
		end
		if ((state_q == ST_DIV) && div2_vld) begin
			page_q <= div2_rem;
		end
		if (state_q == ST_MAP) begin
			fault_q <= !map_hit;
			frame_q <= map_hit ? map_rdata[PG_W-1:0] : nff_q;
		end
		if (state_q == ST_ADDR) begin
			paddr_q <= pa_full[PADDR_W-1:0];
		end
		if (rsp_load) begin
			rsp_fault_q  <= fault_q;
			frame_num_q  <= frame_ext[FRAME_OUT_W-1:0];
			phys_addr_q  <= paddr_q;
			data_value_q <= fault_q ? '0 : mem_rdata;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign fault      = rsp_fault_q;
	assign frame_num  = frame_num_q;
	assign phys_addr  = phys_addr_q;
	assign data_value = data_value_q;

endmodule

>>> hdl/dpt_ram.sv
`timescale 1ns / 1ps

module dpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/dpt_cdiv.sv
`timescale 1ns / 1ps

// Divide an unsigned value by a constant: multiply by the scaled reciprocal,
// back-multiply to get the remainder, then one correction step. Three stages.
module dpt_cdiv #(
	parameter int W       = 16,
	parameter int DIVISOR = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [W-1:0]               dividend,
	output logic                       out_valid,
	output logic [W-1:0]               quot,
	output logic [$clog2(DIVISOR)-1:0] rem
);

	localparam int DW = $clog2(DIVISOR + 1);
	localparam int RW = $clog2(DIVISOR);
	localparam longint unsigned RECIP = (64'd1 << (2 * W)) / DIVISOR;
	localparam logic [2*W-1:0] RECIP_V = RECIP[2*W-1:0];
	localparam logic [DW-1:0] DIV_V = DW'(DIVISOR);

	logic [W-1:0]   x_s1;
	logic [3*W-1:0] prod_s1;
	logic [W-1:0]   q_s2;
	logic [W-1:0]   r_s2;
	logic [W-1:0]   q_s3;
	logic [RW-1:0]  r_s3;
	logic           vld_s1;
	logic           vld_s2;
	logic           vld_s3;
	logic [W-1:0]   q_est;
	logic [W+DW-1:0] qd;

	// Advance the stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Estimate quotient, which is exact or one short
	assign q_est = prod_s1[3*W-1:2*W];
	assign qd    = (W + DW)'(q_est) * (W + DW)'(DIV_V);

	always_ff @(posedge clk) begin
		x_s1    <= dividend;
		prod_s1 <= (3 * W)'(dividend) * (3 * W)'(RECIP_V);
		q_s2    <= q_est;
		r_s2    <= x_s1 - qd[W-1:0];
		// Correct an estimate that came out one short
		if (r_s2 >= W'(DIVISOR)) begin
			q_s3 <= q_s2 + W'(1);
			r_s3 <= RW'(r_s2 - W'(DIVISOR));
		end else begin
			q_s3 <= q_s2;
			r_s3 <= r_s2[RW-1:0];
		end
	end

	assign out_valid = vld_s3;
	assign quot      = q_s3;
	assign rem       = r_s3;

endmodule
